/* rtl/sha0_sha1_hash_engine_unit_defines.svh */
// Assertion macros for the hash engine RTL, included by sha_fifo
`ifndef SHA0_SHA1_HASH_ENGINE_UNIT_DEFINES_SVH
`define SHA0_SHA1_HASH_ENGINE_UNIT_DEFINES_SVH

// Condition must hold on every clock edge out of reset
`define SHA_CHK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the following cycle
`define SHA_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types and constants of the SHA-0 / SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha_pkg;

    // queue entry: one big-endian block word plus final-word and overflow flags
    typedef struct packed {
        logic [31:0] word;
        logic        fin;
        logic        ovf;
    } t_qent;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    // word position of the high length word inside a block
    localparam logic [3:0] LEN_WORD_IDX = 4'd14;
    localparam logic [6:0] LAST_ROUND   = 7'd79;
    localparam logic [2:0] LAST_DIGEST  = 3'd4;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_HASH_MODE = 1'b0;

    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        logic [31:0] v;
        unique case (idx)
            3'd0:    v = IV0;
            3'd1:    v = IV1;
            3'd2:    v = IV2;
            3'd3:    v = IV3;
            default: v = IV4;
        endcase
        return v;
    endfunction

endpackage

/* rtl/sha_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_fifo
// Short word queue between the byte front end and the compression core.
// ----------------------------------------------------------------------------
`include "sha0_sha1_hash_engine_unit_defines.svh"
module sha_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sha_pkg::t_qent i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sha_pkg::t_qent o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sha_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `SHA_CHK(a_no_overflow, !(i_push && o_full && !i_pop), "push into full queue")
    `SHA_CHK(a_no_underflow, !(i_pop && !o_valid), "pop from empty queue")
    `SHA_CHK(a_cnt_range, r_cnt <= CW'(DEPTH), "queue count out of range")
endmodule

/* rtl/sha_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front
// Packs message bytes into words, counts length and generates padding.
// ----------------------------------------------------------------------------
module sha_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_byte_valid,
    input  logic           i_last_item,
    output logic           o_push,
    output sha_pkg::t_qent o_push_data,
    input  logic           i_full
);
    typedef enum logic [2:0] {F_IDLE, F_PAD, F_ZERO, F_LENH, F_LENL} t_fstate;

    t_fstate     r_state;
    logic [32:0] r_cnt;
    logic        r_ovf;
    logic [31:0] r_acc;
    logic [3:0]  r_widx;
    logic        w_fire;
    logic [32:0] n_cnt;
    logic [31:0] w_pad;

    assign o_in_ready = (r_state == F_IDLE) && !i_full;
    assign w_fire     = i_in_valid && o_in_ready;
    assign n_cnt      = r_cnt + 33'd1;

    // final data word with the 0x80 marker after the held bytes
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    w_pad = {sha_pkg::PAD_BYTE, 24'd0};
            2'd1:    w_pad = {r_acc[7:0], sha_pkg::PAD_BYTE, 16'd0};
            2'd2:    w_pad = {r_acc[15:0], sha_pkg::PAD_BYTE, 8'd0};
            default: w_pad = {r_acc[23:0], sha_pkg::PAD_BYTE};
        endcase
    end

    // word toward the queue
    always_comb begin
        o_push      = 1'b0;
        o_push_data = '{word: 32'd0, fin: 1'b0, ovf: r_ovf};
        unique case (r_state)
            F_IDLE: begin
                o_push = w_fire && i_byte_valid && (r_cnt[1:0] == 2'd3);
                o_push_data.word = {r_acc[23:0], i_data_byte};
            end
            F_PAD: begin
                o_push = !i_full;
                o_push_data.word = w_pad;
            end
            F_ZERO: begin
                o_push = !i_full;
            end
            F_LENH: begin
                o_push = !i_full;
                o_push_data.word = {28'd0, r_cnt[32:29]};
            end
            default: begin
                o_push = !i_full;
                o_push_data.word = {r_cnt[28:0], 3'd0};
                o_push_data.fin  = 1'b1;
            end
        endcase
    end

    // byte collection and padding sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_widx  <= '0;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (w_fire) begin
                        if (i_byte_valid) begin
                            r_acc <= {r_acc[23:0], i_data_byte};
                            r_cnt <= n_cnt;
                            if (n_cnt[32] || n_cnt == '0) begin
                                r_ovf <= 1'b1;
                            end
                        end
                        if (i_last_item) begin
                            r_state <= F_PAD;
                        end
                    end
                end
                F_PAD: begin
                    if (!i_full) begin
                        r_widx  <= r_cnt[5:2] + 4'd1;
                        r_state <= (r_cnt[5:2] + 4'd1 == sha_pkg::LEN_WORD_IDX) ? F_LENH : F_ZERO;
                    end
                end
                F_ZERO: begin
                    if (!i_full) begin
                        r_widx <= r_widx + 4'd1;
                        if (r_widx + 4'd1 == sha_pkg::LEN_WORD_IDX) begin
                            r_state <= F_LENH;
                        end
                    end
                end
                F_LENH: begin
                    if (!i_full) begin
                        r_state <= F_LENL;
                    end
                end
                default: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                        r_cnt   <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
            endcase
        end
    end
endmodule

/* rtl/sha_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core
// Loads 16 block words, runs 80 rounds, updates the chain, emits digest after the final block.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mode,
    input  logic           i_qvalid,
    input  sha_pkg::t_qent i_qdata,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_word,
    output logic [2:0]     o_index,
    output logic           o_last,
    output logic           o_too_long
);
    typedef enum logic [1:0] {C_LOAD, C_ROUND, C_ADD, C_OUT} t_cstate;

    t_cstate     r_state;
    logic [31:0] r_w [16];
    logic [31:0] r_h [5];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_t;
    logic [3:0]  r_ld;
    logic [2:0]  r_oidx;
    logic        r_fin, r_ovf;
    logic [31:0] w_x, w_next, w_f, w_k, w_sum;

    assign o_pop      = (r_state == C_LOAD) && i_qvalid;
    assign o_valid    = (r_state == C_OUT);
    assign o_index    = r_oidx;
    assign o_last     = (r_oidx == sha_pkg::LAST_DIGEST);
    assign o_too_long = r_ovf;
    assign o_word     = r_h[r_oidx];

    // schedule expansion
    assign w_x    = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_next = i_mode ? {w_x[30:0], w_x[31]} : w_x;

    // round function and constant
    always_comb begin
        if (r_t < 7'd20) begin
            w_f = r_d ^ (r_b & (r_c ^ r_d));
            w_k = 32'h5A827999;
        end else if (r_t < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'h6ED9EBA1;
        end else if (r_t < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = 32'h8F1BBCDC;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = 32'hCA62C1D6;
        end
    end
    assign w_sum = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= i_qdata.word;
            if (r_ld == 4'd15) begin
                {r_a, r_b, r_c, r_d, r_e} <= {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
                r_fin <= i_qdata.fin;
                r_ovf <= i_qdata.ovf;
            end
        end
        if (r_state == C_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_next;
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= w_sum;
        end
    end

    // control and chain value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_LOAD;
            r_ld    <= '0;
            r_t     <= '0;
            r_oidx  <= '0;
            for (int i = 0; i < 5; i++) r_h[i] <= sha_pkg::iv_word(3'(i));
        end else begin
            unique case (r_state)
                C_LOAD: begin
                    if (o_pop) begin
                        r_ld <= r_ld + 4'd1;
                        if (r_ld == 4'd15) begin
                            r_t     <= '0;
                            r_state <= C_ROUND;
                        end
                    end
                end
                C_ROUND: begin
                    r_t <= r_t + 7'd1;
                    if (r_t == sha_pkg::LAST_ROUND) begin
                        r_state <= C_ADD;
                    end
                end
                C_ADD: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_oidx  <= '0;
                    r_state <= r_fin ? C_OUT : C_LOAD;
                end
                default: begin
                    if (i_ready) begin
                        if (r_oidx == sha_pkg::LAST_DIGEST) begin
                            for (int i = 0; i < 5; i++) r_h[i] <= sha_pkg::iv_word(3'(i));
                            r_state <= C_LOAD;
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
            endcase
        end
    end
endmodule

/* rtl/sha0_sha1_hash_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha0_sha1_hash_engine_unit
// SHA-1 / SHA-0 message hash, one byte per item, five digest words out.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream: one message byte per item; byte_valid marks real bytes and
//  tlast ends the message (tlast with byte_valid low ends an empty message).
//  Output stream: five 32-bit digest words, word_index 0..4, tlast on the
//  fifth, tuser set on all five if the message passed 2^32-1 bytes.
//  hash_mode (APB, address 0): 1 = SHA-1, 0 = SHA-0; write only while idle.
//  Throughput: a byte is taken per cycle while the 4-word queue has room.
//  The core pops block words only between compressions: a 64-byte block is
//  loaded (queue drain, then one word per four bytes), then runs 80 rounds
//  and one add step. After tlast the front end pads (up to 18 words), then
//  one or two block compressions run before digest word 0 appears.
//  While padding the input is held off. A stalled receiver holds the digest
//  words; the front end keeps taking bytes of the next message until the
//  queue fills. Reset restores SHA-1 mode, the initial chain and count zero.
module sha0_sha1_hash_engine_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data_byte, [8] byte_valid, rest zero
    input  logic        i_s_tlast,   // last_item
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        o_m_tlast,   // last_word
    output logic        o_m_tuser,   // too_long
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    logic           r_mode;
    logic           w_push, w_full, w_pop, w_qvalid;
    sha_pkg::t_qent w_pdata, w_qdata;
    logic [31:0]    w_word;
    logic [2:0]     w_idx;

    // configuration register
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == sha_pkg::REG_HASH_MODE) ? {31'd0, r_mode} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (i_psel && i_penable && i_pwrite &&
                     i_paddr[2] == sha_pkg::REG_HASH_MODE) begin
            r_mode <= i_pwdata[0];
        end
    end

    sha_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_data_byte  (i_s_tdata[7:0]),
        .i_byte_valid (i_s_tdata[8]),
        .i_last_item  (i_s_tlast),
        .o_push       (w_push),
        .o_push_data  (w_pdata),
        .i_full       (w_full)
    );

    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_pdata),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qdata)
    );

    sha_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_qvalid   (w_qvalid),
        .i_qdata    (w_qdata),
        .o_pop      (w_pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_word     (w_word),
        .o_index    (w_idx),
        .o_last     (o_m_tlast),
        .o_too_long (o_m_tuser)
    );

    assign o_m_tdata = {5'd0, w_idx, w_word};
endmodule
